// ===== sv/mf3_pkg.sv =====
// Shared constants, types and median functions for the 3x3 RGB median filter.
package mf3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 3;

  localparam int DIM_W   = 11;
  localparam int IDX_W   = 1;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int CNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int FRAME_W = CNT_W + 1;
  localparam int STEP_W  = $clog2(CNT_W);

  localparam int PEND_MAX = 4 * MAX_WIDTH;
  localparam int PEND_W   = $clog2(PEND_MAX + 1);

  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);

  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic             valid;
    logic             flush;
    logic             emit;
    logic             border;
    logic             use_mid;
    logic             eof;
    logic             fwd;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] px;
  } stage_t;

  typedef struct packed {
    logic            eof;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } res_t;

  function automatic logic [CH_W-1:0] min2(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [CH_W-1:0] max2(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [CH_W-1:0] min3(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
                                           input logic [CH_W-1:0] c);
    return min2(min2(a, b), c);
  endfunction

  function automatic logic [CH_W-1:0] max3(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
                                           input logic [CH_W-1:0] c);
    return max2(max2(a, b), c);
  endfunction

  function automatic logic [CH_W-1:0] med3(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
                                           input logic [CH_W-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Median of nine: max of row minima, median of row medians, min of row maxima.
  function automatic logic [CH_W-1:0] median9(input logic [8:0][CH_W-1:0] v);
    logic [CH_W-1:0] lo_max;
    logic [CH_W-1:0] mid_med;
    logic [CH_W-1:0] hi_min;
    lo_max  = max3(min3(v[0], v[1], v[2]), min3(v[3], v[4], v[5]), min3(v[6], v[7], v[8]));
    mid_med = med3(med3(v[0], v[1], v[2]), med3(v[3], v[4], v[5]), med3(v[6], v[7], v[8]));
    hi_min  = min3(max3(v[0], v[1], v[2]), max3(v[3], v[4], v[5]), max3(v[6], v[7], v[8]));
    return med3(lo_max, mid_med, hi_min);
  endfunction

  function automatic logic [PIX_W-1:0] median_pix(input win_t w);
    logic [8:0][CH_W-1:0] r;
    logic [8:0][CH_W-1:0] g;
    logic [8:0][CH_W-1:0] b;
    for (int i = 0; i < 9; i++) begin
      r[i] = w[i][CH_W-1:0];
      g[i] = w[i][2*CH_W-1:CH_W];
      b[i] = w[i][PIX_W-1:2*CH_W];
    end
    return {median9(b), median9(g), median9(r)};
  endfunction

endpackage

// ===== sv/mf3_ram.sv =====
// Generic simple dual-port RAM with registered read.
module mf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/mf3_ctrl.sv =====
// Register file, position counters, column remainder unit and per-word decisions.
module mf3_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mf3_pkg::IDX_W-1:0]       cfg_index,
  input  logic [mf3_pkg::DIM_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  input  logic [mf3_pkg::CH_W-1:0]        in_red,
  input  logic [mf3_pkg::CH_W-1:0]        in_green,
  input  logic [mf3_pkg::CH_W-1:0]        in_blue,
  input  logic [mf3_pkg::FIFO_CNT_W-1:0]  fifo_count,
  output mf3_pkg::stage_t                 stage,
  output logic [mf3_pkg::COL_W-1:0]       rd_addr
);
  import mf3_pkg::*;

  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;
  logic [DIM_W-1:0]   width_c;
  logic [DIM_W-1:0]   height_c;
  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;
  logic [FRAME_W-1:0] frame_size;
  logic [FRAME_W-1:0] last_row_start;

  logic               busy;
  logic [STEP_W-1:0]  div_step;
  logic [COL_W-1:0]   div_rem;
  logic [CNT_W-1:0]   div_dvd;
  logic [DIM_W-1:0]   div_sh;
  logic [DIM_W-1:0]   div_sub;
  logic [COL_W-1:0]   div_rem_next;

  logic [COL_W-1:0]   input_column;
  logic [PEND_W-1:0]  pending;
  logic [CNT_W-1:0]   out_count;
  logic [COL_W-1:0]   out_col;

  logic               acc;
  logic               is_flush;
  logic [DIM_W-1:0]   col_inc;
  logic [DIM_W-1:0]   ocol_inc;
  logic [PEND_W-1:0]  pend_inc;
  logic [FRAME_W-1:0] oc_ext;
  logic [FRAME_W-1:0] oc_inc;
  logic               is_eof;
  logic               emit_c;
  logic               border_c;
  logic               fwd_c;
  stage_t             stage_next;

  // Clamp the programmed sizes to the supported range.
  always_comb begin
    width_c = image_width;
    if (image_width < DIM_W'(MIN_DIM)) begin
      width_c = DIM_W'(MIN_DIM);
    end else if (image_width > DIM_W'(MAX_WIDTH)) begin
      width_c = DIM_W'(MAX_WIDTH);
    end
    height_c = image_height;
    if (image_height < DIM_W'(MIN_DIM)) begin
      height_c = DIM_W'(MIN_DIM);
    end else if (image_height > DIM_W'(MAX_HEIGHT)) begin
      height_c = DIM_W'(MAX_HEIGHT);
    end
  end

  // One restoring step: bring down the next bit of the output index.
  always_comb begin
    div_sh       = DIM_W'({div_rem, div_dvd[CNT_W-1]});
    div_sub      = div_sh - width_c;
    div_rem_next = (div_sh >= width_c) ? div_sub[COL_W-1:0] : div_sh[COL_W-1:0];
  end

  always_comb begin
    in_ready = !busy && (fifo_count + FIFO_CNT_W'(stage.emit) < FIFO_CNT_W'(FIFO_DEPTH));

    acc      = in_valid && in_ready;
    is_flush = (op == OP_FLUSH);
    col_inc  = DIM_W'(input_column) + 1'b1;
    ocol_inc = DIM_W'(out_col) + 1'b1;
    pend_inc = (pending == PEND_W'(PEND_MAX)) ? pending : pending + 1'b1;
    oc_ext   = FRAME_W'(out_count);
    oc_inc   = oc_ext + 1'b1;
    is_eof   = (oc_inc >= frame_size);

    if (is_flush) begin
      emit_c = (pending != '0) &&
               ((oc_ext >= frame_size) || (oc_ext + FRAME_W'(pending) >= frame_size));
    end else begin
      emit_c = (pend_inc >= PEND_W'(width_r) + PEND_W'(2));
    end

    border_c = (oc_ext < FRAME_W'(width_r)) || (oc_ext >= last_row_start) ||
               (out_col == '0) || (ocol_inc >= width_r);

    rd_addr = is_flush ? out_col : input_column;
    // The word now in stage writes the line stores this cycle: forward it.
    fwd_c   = stage.valid && !stage.flush && (stage.col == rd_addr);

    stage_next         = '0;
    stage_next.valid   = acc;
    stage_next.flush   = is_flush;
    stage_next.emit    = acc && emit_c;
    stage_next.border  = border_c;
    stage_next.use_mid = (pending <= PEND_W'(width_r));
    stage_next.eof     = is_eof;
    stage_next.fwd     = acc && fwd_c;
    stage_next.col     = input_column;
    stage_next.px      = {in_blue, in_green, in_red};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame products are registered in turn and settle well inside the remainder run.
  always_ff @(posedge clk) begin
    width_r        <= width_c;
    height_r       <= height_c;
    frame_size     <= FRAME_W'(width_r) * FRAME_W'(height_r);
    last_row_start <= frame_size - FRAME_W'(width_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      div_step <= '0;
      div_rem  <= '0;
      div_dvd  <= '0;
    end else if (cfg_we) begin
      busy     <= 1'b1;
      div_step <= '0;
      div_rem  <= '0;
      div_dvd  <= out_count;
    end else if (busy) begin
      div_step <= div_step + 1'b1;
      div_rem  <= div_rem_next;
      div_dvd  <= div_dvd << 1;
      if (div_step == STEP_W'(CNT_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_column <= '0;
      pending      <= '0;
      out_count    <= '0;
      out_col      <= '0;
    end else begin
      if (busy && !cfg_we && div_step == STEP_W'(CNT_W - 1)) begin
        out_col <= div_rem_next;
      end
      if (acc) begin
        if (!is_flush) begin
          input_column <= (col_inc >= width_r) ? '0 : col_inc[COL_W-1:0];
          pending      <= emit_c ? pend_inc - 1'b1 : pend_inc;
        end else if (emit_c) begin
          pending <= pending - 1'b1;
        end
        if (emit_c) begin
          out_count <= is_eof ? '0 : oc_inc[CNT_W-1:0];
          out_col   <= (is_eof || ocol_inc >= width_r) ? '0 : ocol_inc[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= stage_next;
    end
  end

endmodule

// ===== sv/mf3_window.sv =====
// 3x3 window, line store write-back and median / pass-through result select.
module mf3_window (
  input  logic                       clk,
  input  logic                       rst,
  input  mf3_pkg::stage_t            stage,
  input  logic [mf3_pkg::PIX_W-1:0]  upper_rd,
  input  logic [mf3_pkg::PIX_W-1:0]  middle_rd,
  output logic                       wr_en,
  output logic [mf3_pkg::COL_W-1:0]  wr_addr,
  output logic [mf3_pkg::PIX_W-1:0]  upper_wr,
  output logic [mf3_pkg::PIX_W-1:0]  middle_wr,
  output logic                       res_valid,
  output mf3_pkg::res_t              res
);
  import mf3_pkg::*;

  win_t             window;
  win_t             win_next;
  logic [PIX_W-1:0] fwd_upper;
  logic [PIX_W-1:0] fwd_middle;
  logic [PIX_W-1:0] up_eff;
  logic [PIX_W-1:0] mid_eff;
  logic [PIX_W-1:0] med;
  logic [PIX_W-1:0] pick;

  always_comb begin
    up_eff  = stage.fwd ? fwd_upper  : upper_rd;
    mid_eff = stage.fwd ? fwd_middle : middle_rd;

    // Shift left; the newest column enters on the right.
    win_next[0] = window[1];
    win_next[1] = window[2];
    win_next[2] = up_eff;
    win_next[3] = window[4];
    win_next[4] = window[5];
    win_next[5] = mid_eff;
    win_next[6] = window[7];
    win_next[7] = window[8];
    win_next[8] = stage.px;

    med = median_pix(win_next);

    if (stage.flush) begin
      pick = stage.use_mid ? mid_eff : up_eff;
    end else begin
      pick = stage.border ? win_next[4] : med;
    end

    wr_en     = stage.valid && !stage.flush;
    wr_addr   = stage.col;
    upper_wr  = mid_eff;
    middle_wr = stage.px;

    res_valid = stage.valid && stage.emit;
    res.eof   = stage.eof;
    res.red   = pick[CH_W-1:0];
    res.green = pick[2*CH_W-1:CH_W];
    res.blue  = pick[PIX_W-1:2*CH_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (wr_en) begin
      window <= win_next;
    end
  end

  // Hold what the line stores just took, for a read of the same column next cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_upper  <= mid_eff;
      fwd_middle <= stage.px;
    end
  end

endmodule

// ===== sv/mf3_out_fifo.sv =====
// Small result queue between the filter stage and the output channel.
module mf3_out_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  mf3_pkg::res_t                   push_data,
  output logic                            pop_valid,
  input  logic                            pop_ready,
  output mf3_pkg::res_t                   pop_data,
  output logic [mf3_pkg::FIFO_CNT_W-1:0]  count
);
  import mf3_pkg::*;

  res_t                  slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  pop;

  always_comb begin
    pop_valid = (count != '0);
    pop_data  = slots[rd_ptr];
    pop       = pop_valid && pop_ready;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/median_filter_3x3_rgb_unit.sv =====
// Top level of the streaming 3x3 RGB median filter.
//
// Channel  Dir  Handshake               Word
// in       in   in_valid / in_ready     op, in_red, in_green, in_blue
// out      out  out_valid / out_ready   out_red, out_green, out_blue, end_of_frame
// cfg      in   cfg_we, no wait         cfg_index, cfg_data
//
// Takes one input word per cycle while in_ready is high. A result word passes through the stage
// register into the output queue and is offered on the output once older queued words are taken.
// Reset and every register write start a remainder run (one bit of the output index per cycle
// through the restoring divider); in_ready stays low during it.
// The line stores are not cleared. A four-entry output queue decouples the sides: in_ready
// drops during the remainder run or when queued words plus an emitting stage word reach four.
module median_filter_3x3_rgb_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [mf3_pkg::IDX_W-1:0]  cfg_index,
  input  logic [mf3_pkg::DIM_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       op,
  input  logic [mf3_pkg::CH_W-1:0]   in_red,
  input  logic [mf3_pkg::CH_W-1:0]   in_green,
  input  logic [mf3_pkg::CH_W-1:0]   in_blue,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mf3_pkg::CH_W-1:0]   out_red,
  output logic [mf3_pkg::CH_W-1:0]   out_green,
  output logic [mf3_pkg::CH_W-1:0]   out_blue,
  output logic                       end_of_frame
);
  import mf3_pkg::*;

  stage_t                stage;
  logic [COL_W-1:0]      rd_addr;
  logic [PIX_W-1:0]      upper_rd;
  logic [PIX_W-1:0]      middle_rd;
  logic                  wr_en;
  logic [COL_W-1:0]      wr_addr;
  logic [PIX_W-1:0]      upper_wr;
  logic [PIX_W-1:0]      middle_wr;
  logic                  res_valid;
  res_t                  res;
  res_t                  out_word;
  logic [FIFO_CNT_W-1:0] fifo_count;

  // Counters, sizes and the decision for each accepted word; the stage register leaves here.
  mf3_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .fifo_count (fifo_count),
    .stage      (stage),
    .rd_addr    (rd_addr)
  );

  // Two previous lines, read at the accepting edge, written back from the stage.
  mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_upper (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (upper_wr),
    .raddr (rd_addr),
    .rdata (upper_rd)
  );

  mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_middle (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (middle_wr),
    .raddr (rd_addr),
    .rdata (middle_rd)
  );

  // Window shift and median select for the word in the stage.
  mf3_window u_window (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .upper_rd  (upper_rd),
    .middle_rd (middle_rd),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .upper_wr  (upper_wr),
    .middle_wr (middle_wr),
    .res_valid (res_valid),
    .res       (res)
  );

  // Hold finished results until the output side takes them.
  mf3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (out_word),
    .count     (fifo_count)
  );

  assign out_red      = out_word.red;
  assign out_green    = out_word.green;
  assign out_blue     = out_word.blue;
  assign end_of_frame = out_word.eof;

  // A result from the stage always finds room in the queue.
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (fifo_count != FIFO_CNT_W'(FIFO_DEPTH)) || (out_valid && out_ready))
    else $error("result word arrived at a full output queue");

  // Forwarding is only taken when the previous stage word wrote the line stores.
  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    stage.fwd |-> $past(stage.valid && !stage.flush))
    else $error("line store forward without a preceding pixel write");

endmodule

// ===== verif/tb_median_filter_3x3_rgb_unit.sv =====
// Self-checking testbench for the streaming 3x3 RGB median filter, predicting every output word.
module tb_median_filter_3x3_rgb_unit;
  import mf3_pkg::*;

  // One input word as the sender offers it.
  typedef struct packed {
    logic            op;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_word_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam int unsigned SETTLE_CYCLES = 30;   // past the remainder run
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PRINT_CAP     = 100;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             op = OP_PIXEL;
  logic [CH_W-1:0]  in_red = '0;
  logic [CH_W-1:0]  in_green = '0;
  logic [CH_W-1:0]  in_blue = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;
  logic             end_of_frame;

  // Words waiting to be offered, and filtered pixels waiting to come out.
  pixel_word_t pixel_words_q[$];
  res_t        filtered_q[$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_request = 1'b0;
  logic        rx_hold = 1'b0;
  int unsigned fault_count = 0;
  int unsigned words_checked = 0;

  // Shadow of the filter: line stores, window, positions and the two size registers.
  logic [PIX_W-1:0] upper_line [MAX_WIDTH] = '{default: '0};
  logic [PIX_W-1:0] middle_line [MAX_WIDTH] = '{default: '0};
  logic [PIX_W-1:0] window_px [9] = '{default: '0};
  int unsigned      cur_col = 0;
  int unsigned      out_idx = 0;
  int unsigned      held = 0;
  logic [DIM_W-1:0] width_reg = RESET_WIDTH;
  logic [DIM_W-1:0] height_reg = RESET_HEIGHT;

  median_filter_3x3_rgb_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .end_of_frame (end_of_frame)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // Median of one channel over the current window, by insertion sort.
  function automatic logic [CH_W-1:0] channel_median(input int sh);
    logic [CH_W-1:0] v [9];
    logic [CH_W-1:0] t;
    int              j;
    for (int i = 0; i < 9; i++) v[i] = window_px[i][sh +: CH_W];
    for (int i = 1; i < 9; i++) begin
      t = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > t) begin
        v[j + 1] = v[j];
        j--;
      end
      v[j + 1] = t;
    end
    return v[4];
  endfunction

  // Advance the shadow filter by one accepted word; tell whether it releases a pixel.
  function automatic void advance_filter(input pixel_word_t w, output bit produced,
                                         output res_t r);
    int unsigned      wd;
    int unsigned      ht;
    int unsigned      frame;
    int unsigned      col;
    int unsigned      remain;
    int unsigned      orow;
    int unsigned      ocol;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] sel;
    wd = clamp_dim(width_reg, MAX_WIDTH);
    ht = clamp_dim(height_reg, MAX_HEIGHT);
    frame = wd * ht;
    produced = 1'b0;
    sel = '0;
    r = '0;
    if (w.op == OP_PIXEL) begin
      col = (cur_col >= MAX_WIDTH) ? 0 : cur_col;
      px = {w.blue, w.green, w.red};
      up = upper_line[col];
      mid = middle_line[col];
      upper_line[col] = mid;
      middle_line[col] = px;
      // Shift the window left; the new column is upper, middle, incoming.
      for (int k = 0; k < 3; k++) begin
        window_px[3*k] = window_px[3*k+1];
        window_px[3*k+1] = window_px[3*k+2];
      end
      window_px[2] = up;
      window_px[5] = mid;
      window_px[8] = px;
      cur_col = col + 1;
      if (cur_col >= wd) cur_col = 0;
      if (held < PEND_MAX) held++;
      if (held >= wd + 2) begin
        orow = out_idx / wd;
        ocol = out_idx % wd;
        // Border pixels pass through; interior ones take the per-channel median.
        if (orow == 0 || orow + 1 >= ht || ocol == 0 || ocol + 1 >= wd)
          sel = window_px[4];
        else
          sel = {channel_median(2*CH_W), channel_median(CH_W), channel_median(0)};
        produced = 1'b1;
      end
    end else begin
      // A flush only drains once the current output frame is fully received.
      remain = (out_idx < frame) ? frame - out_idx : 1;
      if (held != 0 && held >= remain) begin
        col = out_idx % wd;
        sel = (held - 1 < wd) ? middle_line[col] : upper_line[col];
        produced = 1'b1;
      end
    end
    if (produced) begin
      r.red = sel[CH_W-1:0];
      r.green = sel[2*CH_W-1:CH_W];
      r.blue = sel[PIX_W-1:2*CH_W];
      r.eof = (out_idx + 1 >= frame);
      out_idx = r.eof ? 0 : out_idx + 1;
      if (held != 0) held--;
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    // Keep the log short on a badly broken block; every fault still counts.
    if (fault_count < PRINT_CAP)
      $display("ERROR word %0d: %s is %0h, expected %0h", words_checked, what, got, want);
    fault_count++;
  endtask

  function automatic void queue_word(input logic o, input logic [CH_W-1:0] r,
                                     input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
    pixel_words_q.push_back('{op: o, red: r, green: g, blue: b});
  endfunction

  function automatic void queue_flushes(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      queue_word(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // Random pixels: full range, a narrow band (many equal values), or only 0 and 255.
  // Now and then a flush lands among them as noise.
  function automatic void queue_frame_pixels(input int unsigned n, input int unsigned style);
    logic [CH_W-1:0] base [3];
    logic [CH_W-1:0] ch [3];
    for (int c = 0; c < 3; c++) base[c] = 8'($urandom);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(24) == 0) queue_flushes(1);
      for (int c = 0; c < 3; c++) begin
        case (style)
          0: ch[c] = 8'($urandom);
          1: ch[c] = base[c] + 8'($urandom_range(3));
          default: ch[c] = $urandom_range(1) ? 8'hFF : 8'h00;
        endcase
      end
      queue_word(OP_PIXEL, ch[0], ch[1], ch[2]);
    end
  endfunction

  task automatic set_idling(input idle_mode_t m);
    case (m)
      IDLE_NONE: begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end
      IDLE_SENDER: begin
        tx_idle_pct <= 67;
        rx_idle_pct <= 0;
      end
      IDLE_RECEIVER: begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 67;
      end
      default: begin
        tx_idle_pct <= 22;
        rx_idle_pct <= 22;
      end
    endcase
  endtask

  // Write one size register; only called with nothing in flight.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every word went in and every expected pixel came out, then let
  // the block finish any flush that released nothing.
  task automatic wait_idle();
    while (pixel_words_q.size() != 0 || in_valid || filtered_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender: on acceptance, predict; then offer the next word or drop valid.
  always @(posedge clk) begin : drive_words
    bit   made;
    res_t res;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_filter({op, in_red, in_green, in_blue}, made, res);
        if (made) filtered_q.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (pixel_words_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          pixel_word_t nxt;
          nxt = pixel_words_q.pop_front();
          in_valid <= 1'b1;
          op <= nxt.op;
          in_red <= nxt.red;
          in_green <= nxt.green;
          in_blue <= nxt.blue;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall at random, or hard during the hold-off.
  always @(posedge clk) begin
    if (rx_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Check each accepted output word against the oldest predicted pixel.
  always @(posedge clk) begin : check_words
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (filtered_q.size() == 0) begin
        report_mismatch("unexpected word, red", out_red, 0);
      end else begin
        want = filtered_q.pop_front();
        if (out_red !== want.red) report_mismatch("out_red", out_red, want.red);
        if (out_green !== want.green) report_mismatch("out_green", out_green, want.green);
        if (out_blue !== want.blue) report_mismatch("out_blue", out_blue, want.blue);
        if (end_of_frame !== want.eof)
          report_mismatch("end_of_frame", end_of_frame, want.eof);
      end
      words_checked++;
    end
  end

  // Hold off the receiver for a long stretch while the sender keeps pushing,
  // so the output queue fills and in_ready drops.
  initial begin : receiver_hold
    wait (hold_request);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : limit_guard
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int unsigned      pixels_sent;
    int unsigned      chunk;
    int unsigned      wd;
    int unsigned      ht;
    int unsigned      n_frames;
    logic [DIM_W-1:0] w_cfg;
    logic [DIM_W-1:0] h_cfg;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: smallest frame, set through values below range that clamp to 3x3.
    set_idling(IDLE_NONE);
    write_reg(REG_IMAGE_WIDTH, '0);
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(1));
    queue_word(OP_PIXEL, 8'h00, 8'h00, 8'h00);
    queue_word(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    queue_word(OP_PIXEL, 8'h55, 8'hAA, 8'h0F);
    // Flush mid-frame: frame not yet received, so nothing comes out.
    queue_word(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF);
    queue_word(OP_PIXEL, 8'hAA, 8'h55, 8'hF0);
    queue_word(OP_PIXEL, 8'h80, 8'h7F, 8'h01);
    queue_word(OP_PIXEL, 8'h01, 8'hFE, 8'h80);
    queue_word(OP_PIXEL, 8'hFF, 8'h00, 8'hFF);
    queue_word(OP_PIXEL, 8'h00, 8'hFF, 8'h00);
    queue_word(OP_PIXEL, 8'h7F, 8'h80, 8'hFE);
    // Back-to-back frame pushes out the tail of the first one.
    for (int i = 0; i < 9; i++)
      queue_word(OP_PIXEL, 8'(i * 29), 8'(255 - i * 31), 8'(i * i * 7));
    // Drain the last line plus one; the fifth flush finds nothing pending.
    queue_flushes(5);
    wait_idle();

    // Widest line, height below range clamps to 3. Fills every column of both line stores.
    set_idling(IDLE_SENDER);
    write_reg(REG_IMAGE_WIDTH, DIM_W'(MAX_WIDTH));
    write_reg(REG_IMAGE_HEIGHT, '0);
    queue_frame_pixels(MAX_WIDTH * 3, 0);
    queue_flushes(MAX_WIDTH + 2);
    wait_idle();

    // Tallest frame: both values above and below range. Stall the receiver here.
    set_idling(IDLE_NONE);
    write_reg(REG_IMAGE_WIDTH, DIM_W'(2));
    write_reg(REG_IMAGE_HEIGHT, '1);
    queue_frame_pixels(3 * MAX_HEIGHT, 1);
    queue_flushes(4);
    hold_request = 1'b1;
    wait_idle();

    // Random frames of small sizes, mostly drained cleanly; some drains cut short.
    pixels_sent = 0;
    chunk = 0;
    while (pixels_sent < 1000) begin
      set_idling(idle_mode_t'(chunk % 4));
      if (chunk % 3 == 0 || $urandom_range(1) == 1) begin
        w_cfg = ($urandom_range(7) == 0) ? DIM_W'($urandom_range(2))
                                         : DIM_W'($urandom_range(3, 10));
        h_cfg = ($urandom_range(7) == 0) ? DIM_W'($urandom_range(2))
                                         : DIM_W'($urandom_range(3, 6));
        write_reg(REG_IMAGE_WIDTH, w_cfg);
        write_reg(REG_IMAGE_HEIGHT, h_cfg);
      end
      wd = clamp_dim(width_reg, MAX_WIDTH);
      ht = clamp_dim(height_reg, MAX_HEIGHT);
      n_frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < n_frames; f++) begin
        queue_frame_pixels(wd * ht, $urandom_range(2));
        pixels_sent += wd * ht;
      end
      if ($urandom_range(7) == 0) queue_flushes($urandom_range(wd));
      else queue_flushes(wd + 1 + $urandom_range(2));
      wait_idle();
      chunk++;
    end

    // Change the width mid-frame: shrink, then grow; positions past the end wrap.
    set_idling(IDLE_BOTH);
    write_reg(REG_IMAGE_WIDTH, DIM_W'(8));
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(4));
    queue_frame_pixels(13, 0);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, DIM_W'(5));
    queue_frame_pixels(12, 0);
    queue_flushes(8);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, DIM_W'(12));
    queue_frame_pixels(30, 2);
    queue_flushes(14);
    wait_idle();

    if (fault_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
